@@ rtl/core/block_scaled_int8_dot_product_unit_assert.svh @@
// assertion macros for the block-scaled dot product rtl, used by its back end
`ifndef BLOCK_SCALED_INT8_DOT_PRODUCT_UNIT_ASSERT_SVH
`define BLOCK_SCALED_INT8_DOT_PRODUCT_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define BSDP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsdp: same-cycle check failed");

// next-cycle implication, masked during reset
`define BSDP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsdp: next-cycle check failed");

`endif

@@ rtl/core/bsdp_pkg.sv @@
// shared types and constants of the block-scaled int8 dot product unit
package bsdp_pkg;

   // field widths fixed by the interface
   localparam int ELEM_W       = 8;
   localparam int SCALE_W      = 16;
   localparam int SCALE_PROD_W = 2 * SCALE_W;
   localparam int ACC_W        = 64;
   localparam int RESULT_FRAC_BITS = 24;

   // parameter defaults
   localparam int BLOCK_LEN_DEF       = 32;
   localparam int SCALE_FRAC_BITS_DEF = 12;

   // depth of the fold queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // saturation bounds of the accumulator
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // input item
   typedef struct packed {
      logic signed [ELEM_W-1:0]  act_value;
      logic signed [ELEM_W-1:0]  wgt_value;
      logic signed [SCALE_W-1:0] act_scale;
      logic signed [SCALE_W-1:0] wgt_scale;
      logic                      last_element;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [ACC_W-1:0] dot_result;
      logic                    saturated;
   } rsp_type;

   // scales and end mark that travel with a block sum to the back end
   typedef struct packed {
      logic signed [SCALE_W-1:0] act_scale;
      logic signed [SCALE_W-1:0] wgt_scale;
      logic                      last_element;
   } fold_type;

   // fold queue status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCALE,
      BK_TERM,
      BK_ALIGN,
      BK_ACC
   } back_state_type;

endpackage

@@ rtl/core/bsdp_queue.sv @@
// small register fifo holding block sums waiting for the scale fold
module bsdp_queue #(
   parameter int DATA_W = 54
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          head_data,
   output bsdp_pkg::queue_status_type q_status
);

   localparam int DEPTH = bsdp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data      = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

@@ rtl/core/bsdp_front.sv @@
// front end: takes items, sums exact products per block, queues block folds
module bsdp_front #(
   parameter int BLOCK_LEN = bsdp_pkg::BLOCK_LEN_DEF,
   parameter int PART_W    = 16 + $clog2(BLOCK_LEN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bsdp_pkg::req_type          req_data,
   input  bsdp_pkg::queue_status_type q_status,
   output logic                       push,
   output logic signed [PART_W-1:0]   push_bsum,
   output bsdp_pkg::fold_type         push_fold
);

   localparam int CNT_W = $clog2(BLOCK_LEN);

   logic signed [PART_W-1:0]                  partial_ff, partial_in;
   logic [CNT_W-1:0]                          count_ff, count_in;
   logic signed [2*bsdp_pkg::ELEM_W-1:0]      elem_prod;
   logic signed [PART_W-1:0]                  sum;
   logic                                      accept;
   logic                                      blk_end;

   // block sum and element count
   always_comb begin
      accept     = req_valid && !q_status.full;
      elem_prod  = req_data.act_value * req_data.wgt_value;
      sum        = partial_ff + PART_W'(elem_prod);
      blk_end    = (count_ff == CNT_W'(BLOCK_LEN - 1)) || req_data.last_element;
      partial_in = partial_ff;
      count_in   = count_ff;
      if (accept) begin
         if (blk_end) begin
            partial_in = '0;
            count_in   = '0;
         end else begin
            partial_in = sum;
            count_in   = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         count_ff   <= '0;
      end else begin
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

   // completed block goes to the fold queue with the scales of its closing item
   assign req_stall              = q_status.full;
   assign push                   = accept && blk_end;
   assign push_bsum              = sum;
   assign push_fold.act_scale    = req_data.act_scale;
   assign push_fold.wgt_scale    = req_data.wgt_scale;
   assign push_fold.last_element = req_data.last_element;

endmodule

@@ rtl/core/bsdp_back.sv @@
// back end: scales block sums, saturating accumulate, result register
module bsdp_back #(
   parameter int BLOCK_LEN       = bsdp_pkg::BLOCK_LEN_DEF,
   parameter int SCALE_FRAC_BITS = bsdp_pkg::SCALE_FRAC_BITS_DEF,
   parameter int PART_W          = 16 + $clog2(BLOCK_LEN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bsdp_pkg::queue_status_type q_status,
   output logic                       pop,
   input  logic signed [PART_W-1:0]   head_bsum,
   input  bsdp_pkg::fold_type         head_fold,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bsdp_pkg::rsp_type          rsp_data
);

   `include "block_scaled_int8_dot_product_unit_assert.svh"

   localparam int ACC_W   = bsdp_pkg::ACC_W;
   localparam int SS_W    = bsdp_pkg::SCALE_PROD_W;
   localparam int PROD_W  = PART_W + SS_W;
   localparam int PROD_FRAC = 2 * SCALE_FRAC_BITS;
   localparam int SHL = (PROD_FRAC < bsdp_pkg::RESULT_FRAC_BITS) ?
                        bsdp_pkg::RESULT_FRAC_BITS - PROD_FRAC : 0;
   localparam int SHR = (PROD_FRAC > bsdp_pkg::RESULT_FRAC_BITS) ?
                        PROD_FRAC - bsdp_pkg::RESULT_FRAC_BITS : 0;
   localparam int ALN_W = (PROD_W + SHL > ACC_W + 1) ? PROD_W + SHL : ACC_W + 1;
   // half an output lsb, zero when no right shift
   localparam logic signed [ALN_W-1:0] RND = (ALN_W'(1) << SHR) >> 1;

   bsdp_pkg::back_state_type state_ff, state_in;

   logic signed [PART_W-1:0] bsum_ff, bsum_in;
   bsdp_pkg::fold_type       fold_ff, fold_in;
   logic signed [SS_W-1:0]   ss_ff, ss_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  term_ff, term_in;
   logic                     tclip_ff, tclip_in;
   logic signed [ACC_W-1:0]  total_ff, total_in;
   logic                     clip_ff, clip_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   bsdp_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic ld_ss, ld_prod, ld_term, ld_acc, ld_out, hold;

   logic signed [ALN_W-1:0] ext;
   logic signed [ALN_W-1:0] shifted;
   logic [ALN_W-ACC_W:0]    hi_bits;
   logic                    fits;
   logic [ACC_W:0]          sum_wide;
   logic                    ovf;
   logic signed [ACC_W-1:0] total_new;
   logic                    clip_new;

   // a last fold waits while an older result is still held
   assign hold = fold_ff.last_element && rsp_valid_ff && rsp_stall;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsdp_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = bsdp_pkg::BK_SCALE;
            end
         end
         bsdp_pkg::BK_SCALE: state_in = bsdp_pkg::BK_TERM;
         bsdp_pkg::BK_TERM:  state_in = bsdp_pkg::BK_ALIGN;
         bsdp_pkg::BK_ALIGN: state_in = bsdp_pkg::BK_ACC;
         bsdp_pkg::BK_ACC: begin
            if (!hold) begin
               state_in = bsdp_pkg::BK_IDLE;
            end
         end
         default: state_in = bsdp_pkg::BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop     = 1'b0;
      ld_ss   = 1'b0;
      ld_prod = 1'b0;
      ld_term = 1'b0;
      ld_acc  = 1'b0;
      ld_out  = 1'b0;
      case (state_ff)
         bsdp_pkg::BK_IDLE:  pop     = !q_status.empty;
         bsdp_pkg::BK_SCALE: ld_ss   = 1'b1;
         bsdp_pkg::BK_TERM:  ld_prod = 1'b1;
         bsdp_pkg::BK_ALIGN: ld_term = 1'b1;
         bsdp_pkg::BK_ACC: begin
            ld_acc = !hold;
            ld_out = !hold && fold_ff.last_element;
         end
         default: pop = 1'b0;
      endcase
   end

   // scale product, block term, alignment and saturating add
   always_comb begin
      bsum_in = pop ? head_bsum : bsum_ff;
      fold_in = pop ? head_fold : fold_ff;
      ss_in   = ld_ss ? fold_ff.act_scale * fold_ff.wgt_scale : ss_ff;
      prod_in = ld_prod ? bsum_ff * ss_ff : prod_ff;

      ext      = {{(ALN_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      shifted  = ((ext + RND) >>> SHR) <<< SHL;
      hi_bits  = shifted[ALN_W-1:ACC_W-1];
      fits     = (&hi_bits) || !(|hi_bits);
      term_in  = term_ff;
      tclip_in = tclip_ff;
      if (ld_term) begin
         tclip_in = !fits;
         if (fits) begin
            term_in = shifted[ACC_W-1:0];
         end else begin
            term_in = shifted[ALN_W-1] ? bsdp_pkg::ACC_MIN : bsdp_pkg::ACC_MAX;
         end
      end

      sum_wide  = {total_ff[ACC_W-1], total_ff} + {term_ff[ACC_W-1], term_ff};
      ovf       = sum_wide[ACC_W] != sum_wide[ACC_W-1];
      if (ovf) begin
         total_new = sum_wide[ACC_W] ? bsdp_pkg::ACC_MIN : bsdp_pkg::ACC_MAX;
      end else begin
         total_new = sum_wide[ACC_W-1:0];
      end
      clip_new = clip_ff || tclip_ff || ovf;

      total_in    = total_ff;
      clip_in     = clip_ff;
      rsp_data_in = rsp_data_ff;
      if (ld_acc) begin
         if (fold_ff.last_element) begin
            total_in = '0;
            clip_in  = 1'b0;
         end else begin
            total_in = total_new;
            clip_in  = clip_new;
         end
      end
      if (ld_out) begin
         rsp_data_in.dot_result = total_new;
         rsp_data_in.saturated  = clip_new;
      end
      rsp_valid_in = ld_out || (rsp_valid_ff && rsp_stall);
   end

   // control state and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsdp_pkg::BK_IDLE;
         total_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bsum_ff     <= bsum_in;
      fold_ff     <= fold_in;
      ss_ff       <= ss_in;
      prod_ff     <= prod_in;
      term_ff     <= term_in;
      tclip_ff    <= tclip_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result is loaded only into a free or draining output register
   `BSDP_ASSERT_IMP(a_out_free, clock, reset, ld_out, !rsp_valid_ff || !rsp_stall)
   // queue is popped only from idle and never when empty
   `BSDP_ASSERT_IMP(a_pop_idle, clock, reset, pop, state_ff == bsdp_pkg::BK_IDLE && !q_status.empty)
   // a finished last fold leaves a cleared accumulator and a pending result
   `BSDP_ASSERT_NXT(a_last_clear, clock, reset, ld_out, total_ff == '0 && !clip_ff && rsp_valid_ff)

endmodule

@@ rtl/core/block_scaled_int8_dot_product_unit.sv @@
// top level of the block-scaled int8 dot product unit
//
//   port group  direction  payload    transfer
//   req_        in         req_type   req_valid & !req_stall
//   rsp_        out        rsp_type   rsp_valid & !rsp_stall
//
// items enter at one per cycle while the fold queue has room
// each block end or last item goes through the back-end steps (pop, scale
// multiply, block multiply, align, accumulate) in order; four folds can queue
// one fold at a time in the back end; when the queue fills, the input stalls
// reset is synchronous and clears block sums, counters, queue and accumulator
// rsp_stall holds the result; a later last fold waits in the back end
module block_scaled_int8_dot_product_unit #(
   parameter int BLOCK_LEN       = bsdp_pkg::BLOCK_LEN_DEF,
   parameter int SCALE_FRAC_BITS = bsdp_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsdp_pkg::rsp_type rsp_data
);

   localparam int PART_W = 16 + $clog2(BLOCK_LEN);
   localparam int ENTRY_W = PART_W + $bits(bsdp_pkg::fold_type);

   bsdp_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;
   logic signed [PART_W-1:0]   push_bsum;
   logic signed [PART_W-1:0]   head_bsum;
   bsdp_pkg::fold_type         push_fold;
   bsdp_pkg::fold_type         head_fold;
   logic [ENTRY_W-1:0]         head_entry;

   // item intake and block sums
   bsdp_front #(
      .BLOCK_LEN (BLOCK_LEN),
      .PART_W    (PART_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_bsum (push_bsum),
      .push_fold (push_fold)
   );

   // fold queue
   bsdp_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_bsum, push_fold}),
      .pop       (pop),
      .head_data (head_entry),
      .q_status  (q_status)
   );

   assign head_bsum = head_entry[ENTRY_W-1:ENTRY_W-PART_W];
   assign head_fold = head_entry[ENTRY_W-PART_W-1:0];

   // scaling, accumulation and result
   bsdp_back #(
      .BLOCK_LEN       (BLOCK_LEN),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
      .PART_W          (PART_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop       (pop),
      .head_bsum (head_bsum),
      .head_fold (head_fold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
